// ===== rtl/core/qpkt_pkg.sv =====
// Shared types and constants for the quadratic-probe keyed slot table.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package qpkt_pkg;

  localparam int TABLE_SIZE = 64;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 64;
  localparam int TYPE_W     = 4;
  localparam int SLOT_W     = 6;
  localparam int STATUS_W   = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 3'd0,
    ST_NEW     = 3'd1,
    ST_RETYPE  = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    ACT_LOOKUP = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_t;

  // Request from the probe sequencer to the slot memory.
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              clr;
    logic [IDX_W-1:0]  addr;
    logic [KEY_W-1:0]  wr_key;
    logic [TYPE_W-1:0] wr_type;
  } mem_req_t;

  // Result word handed from the sequencer to the output register.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/qpkt_slot_mem.sv =====
// Slot memory: key and type per slot, registered read, per-slot valid bits.
// Depends on qpkt_pkg. An invalid slot reads as key zero, type zero.
`timescale 1ns / 1ps
`default_nettype none

module qpkt_slot_mem (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire qpkt_pkg::mem_req_t         req,
  output logic [qpkt_pkg::KEY_W-1:0]      rd_key,
  output logic [qpkt_pkg::TYPE_W-1:0]     rd_type
);

  logic [qpkt_pkg::TYPE_W+qpkt_pkg::KEY_W-1:0] mem [qpkt_pkg::TABLE_SIZE];
  logic [qpkt_pkg::TABLE_SIZE-1:0]             valid;
  logic [qpkt_pkg::TYPE_W+qpkt_pkg::KEY_W-1:0] rd_word;
  logic                                        rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= {req.wr_type, req.wr_key};
    end
    if (req.rd_en) begin
      rd_word <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= valid[req.addr];
      end
    end
  end

  assign rd_key  = rd_vld ? rd_word[qpkt_pkg::KEY_W-1:0] : '0;
  assign rd_type = rd_vld ? rd_word[qpkt_pkg::TYPE_W+qpkt_pkg::KEY_W-1:qpkt_pkg::KEY_W] : '0;

endmodule

`default_nettype wire

// ===== rtl/core/qpkt_probe_seq.sv =====
// Probe sequencer: walks (key + i*i) mod size one slot per read/check pair.
// Depends on qpkt_pkg; drives qpkt_slot_mem through a mem_req_t.
`timescale 1ns / 1ps
`default_nettype none

module qpkt_probe_seq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire qpkt_pkg::action_t          in_action,
  input  wire logic [qpkt_pkg::KEY_W-1:0] in_key,
  input  wire logic [qpkt_pkg::TYPE_W-1:0] in_type,
  output qpkt_pkg::mem_req_t              mem_req,
  input  wire logic [qpkt_pkg::KEY_W-1:0] rd_key,
  input  wire logic [qpkt_pkg::TYPE_W-1:0] rd_type,
  output logic                            res_valid,
  output qpkt_pkg::res_t                  res,
  input  wire logic                       res_ready
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_CHECK  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  localparam logic [qpkt_pkg::IDX_W-1:0] LAST_PROBE = qpkt_pkg::IDX_W'(qpkt_pkg::TABLE_SIZE - 1);

  state_t                        state, state_next;
  logic [qpkt_pkg::KEY_W-1:0]    key;
  logic [qpkt_pkg::TYPE_W-1:0]   etype;
  logic [qpkt_pkg::IDX_W-1:0]    probe;
  logic [qpkt_pkg::IDX_W-1:0]    sq;
  logic [qpkt_pkg::IDX_W-1:0]    idx;
  qpkt_pkg::res_t                res_next;
  logic                          accept;
  logic                          held_empty;
  logic                          held_match;

  // Shared probe adder: table size is a power of two, so mod is the low bits.
  assign idx        = key[qpkt_pkg::IDX_W-1:0] + sq;
  assign held_empty = (rd_key == '0);
  assign held_match = (rd_key == key);

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_RESULT);

  always_comb begin
    state_next      = state;
    res_next        = res;
    mem_req         = '0;
    mem_req.addr    = idx;
    mem_req.wr_key  = key;
    mem_req.wr_type = etype;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_action == qpkt_pkg::ACT_CLEAR) begin
            mem_req.clr = 1'b1;
            res_next    = '{slot: '0, status: qpkt_pkg::ST_CLEARED};
            state_next  = S_RESULT;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        mem_req.rd_en = 1'b1;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        if (held_empty || held_match) begin
          res_next.slot = qpkt_pkg::SLOT_W'(idx);
          if (held_empty) begin
            mem_req.wr_en   = 1'b1;
            res_next.status = qpkt_pkg::ST_NEW;
          end else if (rd_type != etype) begin
            mem_req.wr_en   = 1'b1;
            res_next.status = qpkt_pkg::ST_RETYPE;
          end else begin
            res_next.status = qpkt_pkg::ST_HIT;
          end
          state_next = S_RESULT;
        end else if (probe == LAST_PROBE) begin
          res_next   = '{slot: '0, status: qpkt_pkg::ST_FULL};
          state_next = S_RESULT;
        end else begin
          state_next = S_READ;
        end
      end
      S_RESULT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (accept) begin
      key   <= in_key;
      etype <= in_type;
      probe <= '0;
      sq    <= '0;
    end else if (state == S_CHECK) begin
      // advance i and keep i*i incrementally: (i+1)^2 = i^2 + 2i + 1
      probe <= probe + 1'b1;
      sq    <= sq + {probe[qpkt_pkg::IDX_W-2:0], 1'b1};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/quadratic_probe_keyed_table.sv =====
// Top level of the quadratic-probe keyed slot table: stream ports and output register.
// Depends on qpkt_pkg, qpkt_slot_mem and qpkt_probe_seq.
`timescale 1ns / 1ps
`default_nettype none

// Keyed slot table with 64 slots and quadratic probing. A lookup word
// (s_tuser = 0) probes slot (key + i*i) mod 64 for i = 0..63 and claims the
// first slot that is empty or already holds the key, writing key and type as
// needed; the result word gives the slot and a status of hit, new insert,
// type changed, or table full (slot 0). A clear word (s_tuser = 1) empties the
// whole table by clearing all per-slot valid bits together and reports "cleared".
// Key zero matches only empty slots and never occupies one.
// Timing: one word at a time. Each probe is a registered read of the
// single-port slot memory, then the compare. A lookup settles on probe k
// (k = 1..64, 64 when the table is full) and its result word then moves into
// the output register, which drives m_tvalid. A clear word skips the probes
// and goes straight to its result. The next input word is taken as soon as
// the result has moved into the output register, even while that result
// still waits for m_tready. After reset the table is empty at once.
module quadratic_probe_keyed_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // [63:0] key, [67:64] entry_type, [71:68] zero
  input  wire logic        s_tuser,   // [0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [5:0] slot, [8:6] status, [15:9] zero
);

  qpkt_pkg::mem_req_t                  mem_req;
  logic [qpkt_pkg::KEY_W-1:0]          rd_key;
  logic [qpkt_pkg::TYPE_W-1:0]         rd_type;
  logic                                res_valid;
  logic                                res_ready;
  qpkt_pkg::res_t                      res;
  qpkt_pkg::res_t                      out_res;
  logic [71:qpkt_pkg::KEY_W+qpkt_pkg::TYPE_W] pad_unused;

  // Padding bits of the input word carry nothing.
  assign pad_unused = s_tdata[71:qpkt_pkg::KEY_W+qpkt_pkg::TYPE_W];

  qpkt_slot_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_key  (rd_key),
    .rd_type (rd_type)
  );

  qpkt_probe_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (qpkt_pkg::action_t'(s_tuser)),
    .in_key    (s_tdata[qpkt_pkg::KEY_W-1:0]),
    .in_type   (s_tdata[qpkt_pkg::KEY_W+qpkt_pkg::TYPE_W-1:qpkt_pkg::KEY_W]),
    .mem_req   (mem_req),
    .rd_key    (rd_key),
    .rd_type   (rd_type),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: load a finished result whenever the register is free or
  // its current word is being taken this cycle; otherwise hold the sequencer.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.status, out_res.slot};

  // A taken word keeps the sequencer busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again right after acceptance");

  // Full and cleared results always report slot zero.
  a_zero_slot: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_res.status == qpkt_pkg::ST_FULL ||
                  out_res.status == qpkt_pkg::ST_CLEARED)) |-> (out_res.slot == '0))
    else $error("full or cleared result with nonzero slot");

  // The memory is never read or cleared in the same cycle as it is written.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> !mem_req.rd_en && !mem_req.clr)
    else $error("slot memory read/clear collides with a write");

  // A clear word produces a cleared result next.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> (res_valid && res.status == qpkt_pkg::ST_CLEARED))
    else $error("clear did not produce a cleared result");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for quadratic_probe_keyed_table: a directed table, then random words.
// Depends on qpkt_pkg and the RTL top level; a table predictor or the row checks each result.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import qpkt_pkg::*;

  localparam int IDLE_LIMIT  = 4000;  // cycles with no word moving on either side
  localparam int RANDOM_WORDS = 1150;
  localparam int DRAIN_CYCLES = 140;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // [63:0] key, [67:64] entry_type, [71:68] zero
  logic        s_tuser;   // [0] action
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [5:0] slot, [8:6] status, [15:9] zero

  quadratic_probe_keyed_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  // Shadow copy of the slot table; key zero marks an empty slot.
  logic [KEY_W-1:0]  shadow_key  [TABLE_SIZE];
  logic [TYPE_W-1:0] shadow_type [TABLE_SIZE];

  res_t pending_results[$];   // slot/status words still owed by the block
  int   errors;
  int   idle_cycles;
  int   burst_left;

  // One row of the directed table. Rows with has_result carry a result that
  // can be read straight off the table contents; others use the predictor.
  typedef struct {
    action_t           act;
    logic [KEY_W-1:0]  key;
    logic [TYPE_W-1:0] typ;
    bit                has_result;
    res_t              result;
  } stim_row_t;

  // Probe the shadow table the way the block does and update it in place.
  function automatic res_t probe_table(action_t act, logic [KEY_W-1:0] key,
                                       logic [TYPE_W-1:0] typ);
    res_t             r;
    logic [KEY_W-1:0] idx;
    r.slot   = '0;
    r.status = ST_FULL;
    if (act == ACT_CLEAR) begin
      for (int s = 0; s < TABLE_SIZE; s++) begin
        shadow_key[s]  = '0;
        shadow_type[s] = '0;
      end
      r.status = ST_CLEARED;
      return r;
    end
    for (int i = 0; i < TABLE_SIZE; i++) begin
      idx = (key % TABLE_SIZE + 64'((i * i) % TABLE_SIZE)) % TABLE_SIZE;
      // skip slots held by some other key
      if (shadow_key[idx] != '0 && shadow_key[idx] != key)
        continue;
      if (shadow_key[idx] == '0) begin
        // key zero lands here too, but the slot stays empty
        shadow_key[idx]  = key;
        shadow_type[idx] = typ;
        r.status = ST_NEW;
      end else if (shadow_type[idx] != typ) begin
        shadow_type[idx] = typ;
        r.status = ST_RETYPE;
      end else begin
        r.status = ST_HIT;
      end
      r.slot = idx[SLOT_W-1:0];
      return r;
    end
    return r;
  endfunction

  // Drive one word at the falling edge, hold it until it is taken, then log
  // what the block owes for it. Bursts of random length are mostly broken by gaps.
  task automatic send_word(action_t act, logic [KEY_W-1:0] key, logic [TYPE_W-1:0] typ,
                           bit has_result, res_t result);
    res_t r;
    int   gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, typ, key};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    r = probe_table(act, key, typ);
    if (has_result)
      r = result;
    pending_results.push_back(r);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver: the ready pattern redraws its mode periodically so stalls land
  // on every phase of a lookup, with long stretches of no stall at all.
  int stall_tick;
  int stall_mode;
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 300 == 0)
      stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((stall_tick % 9) < 4);
    endcase
  end

  // Compare each result word with the oldest owed one; also run the watchdog.
  always @(posedge clk) begin : check_results
    res_t               want;
    logic [SLOT_W-1:0]  got_slot;
    status_t            got_status;
    if (!rst && m_tvalid && m_tready) begin
      got_slot   = m_tdata[5:0];
      got_status = status_t'(m_tdata[8:6]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, slot %0d status %0d",
                 $time, got_slot, got_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got_slot !== want.slot) begin
          $display("%0t: slot mismatch, expected %0d, got %0d", $time, want.slot, got_slot);
          errors++;
        end
        if (got_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, got_status);
          errors++;
        end
        if (m_tdata[15:9] !== '0) begin
          $display("%0t: pad bits mismatch, expected 0, got %0h", $time, m_tdata[15:9]);
          errors++;
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  function automatic res_t mk_res(int slot, status_t st);
    res_t r;
    r.slot   = slot[SLOT_W-1:0];
    r.status = st;
    return r;
  endfunction

  initial begin : stimulus
    stim_row_t         plan[$];
    res_t              none;
    logic [KEY_W-1:0]  known_keys[$];
    logic [TYPE_W-1:0] known_types[$];
    logic [KEY_W-1:0]  key;
    logic [TYPE_W-1:0] typ;
    int                pick;
    int                j;

    clk        = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    m_tready   = 1'b0;
    errors     = 0;
    idle_cycles = 0;
    burst_left = 0;
    stall_tick = 0;
    stall_mode = 0;
    none       = mk_res(0, ST_HIT);
    for (int s = 0; s < TABLE_SIZE; s++) begin
      shadow_key[s]  = '0;
      shadow_type[s] = '0;
    end

    // Directed table. The twelve inserts after the clear take every slot that
    // squares mod 64 reach from base 0, so a later new key with base 0 finds the
    // table full; key zero then has no empty slot left either.
    plan = '{
      '{ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 1'b1, mk_res(63, ST_NEW)},
      '{ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 1'b1, mk_res(63, ST_HIT)},
      '{ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'h0, 1'b1, mk_res(63, ST_RETYPE)},
      '{ACT_LOOKUP, 64'd0,   4'h5, 1'b1, mk_res(0, ST_NEW)},
      '{ACT_LOOKUP, 64'd0,   4'h7, 1'b1, mk_res(0, ST_NEW)},
      '{ACT_CLEAR,  64'd0,   4'h0, 1'b1, mk_res(0, ST_CLEARED)},
      '{ACT_LOOKUP, 64'd64,  4'h1, 1'b0, none},
      '{ACT_LOOKUP, 64'd65,  4'h2, 1'b0, none},
      '{ACT_LOOKUP, 64'd68,  4'h3, 1'b0, none},
      '{ACT_LOOKUP, 64'd73,  4'h4, 1'b0, none},
      '{ACT_LOOKUP, 64'd80,  4'h5, 1'b0, none},
      '{ACT_LOOKUP, 64'd81,  4'h6, 1'b0, none},
      '{ACT_LOOKUP, 64'd89,  4'h7, 1'b0, none},
      '{ACT_LOOKUP, 64'd97,  4'h8, 1'b0, none},
      '{ACT_LOOKUP, 64'd100, 4'h9, 1'b0, none},
      '{ACT_LOOKUP, 64'd105, 4'hA, 1'b0, none},
      '{ACT_LOOKUP, 64'd113, 4'hB, 1'b0, none},
      '{ACT_LOOKUP, 64'd121, 4'hC, 1'b0, none},
      '{ACT_LOOKUP, 64'd128, 4'h1, 1'b1, mk_res(0, ST_FULL)},
      '{ACT_LOOKUP, 64'd64,  4'h1, 1'b0, none},
      '{ACT_LOOKUP, 64'h8000_0000_0000_0000, 4'hE, 1'b0, none},
      '{ACT_LOOKUP, 64'd0,   4'h3, 1'b0, none},
      '{ACT_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 1'b1, mk_res(0, ST_CLEARED)}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[r])
      send_word(plan[r].act, plan[r].key, plan[r].typ, plan[r].has_result, plan[r].result);
    wait_results_drained();

    // Random part: lookups of known keys (hits and type changes), fresh keys,
    // half of them with crowded bases to fill probe chains up to full, a few
    // key-zero lookups and the odd clear.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 250 == 125)
        wait_results_drained();
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_word(ACT_CLEAR, {$urandom, $urandom}, 4'($urandom), 1'b0, none);
        known_keys.delete();
        known_types.delete();
        continue;
      end
      if (pick < 5) begin
        send_word(ACT_LOOKUP, '0, 4'($urandom), 1'b0, none);
        continue;
      end
      if (pick < 50 && known_keys.size() != 0) begin
        j   = $urandom_range(0, known_keys.size() - 1);
        key = known_keys[j];
        // keep the stored type most of the time to hit, else retype
        typ = ($urandom_range(0, 9) < 6) ? known_types[j] : 4'($urandom);
        known_types[j] = typ;
      end else begin
        key = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 1)
          key[5:0] = 6'($urandom_range(0, 7));
        typ = 4'($urandom);
        if (known_keys.size() < TABLE_SIZE) begin
          known_keys.push_back(key);
          known_types.push_back(typ);
        end else begin
          j = $urandom_range(0, TABLE_SIZE - 1);
          known_keys[j]  = key;
          known_types[j] = typ;
        end
      end
      send_word(ACT_LOOKUP, key, typ, 1'b0, none);
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/qpkt_pkg.sv
rtl/core/qpkt_slot_mem.sv
rtl/core/qpkt_probe_seq.sv
rtl/core/quadratic_probe_keyed_table.sv
sim/testbench.sv
